// ===== rtl/dpb_pkg.sv =====
// shared types, constants and register codes of the depth pixel back-projection unit
package dpb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int FOC_W   = 20;
	localparam int D_W     = 16;
	localparam int LAB_W   = 8;
	localparam int XN_W    = 31;
	localparam int XQ_W    = 32;
	localparam int SQ_W    = 62;
	localparam int NORM_W  = 64;
	localparam int ROOT_W  = 32;
	localparam int REM_W   = 34;
	localparam int Z_W     = 24;
	localparam int XY_W    = 25;
	localparam int PROD_W  = 55;
	localparam int IDX_W   = 3;
	localparam int XDIV_STEPS = 32;
	localparam int ROOT_STEPS = 32;

	localparam logic [FOC_W-1:0] FOCAL_X_RST  = 20'd128000;
	localparam logic [FOC_W-1:0] FOCAL_Y_RST  = 20'd128000;
	localparam logic [FOC_W-1:0] CENTER_X_RST = 20'd81920;
	localparam logic [FOC_W-1:0] CENTER_Y_RST = 20'd61440;
	localparam logic [D_W-1:0]   MIN_RANGE_RST = 16'd0;
	localparam logic [D_W-1:0]   MAX_RANGE_RST = 16'd65535;

	localparam logic [XN_W-1:0] XN_SAT = 31'h7FFF_FFFF;
	localparam logic [Z_W-1:0]  Z_MAX  = 24'hFF_FFFF;
	localparam logic [XY_W-1:0] XY_MAX = 25'h0FF_FFFF;
	localparam logic [XY_W-1:0] XY_MIN = 25'h100_0000;
	localparam logic [NORM_W-1:0] NORM_ONE = 64'h0000_0001_0000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_MIN_RANGE = 3'd4,
		REG_MAX_RANGE = 3'd5
	} cfg_reg_t;

	// side data while the normalized coordinates are divided out
	typedef struct packed {
		logic             xneg;
		logic             yneg;
		logic             xovf;
		logic             yovf;
		logic [D_W-1:0]   depth;
		logic [LAB_W-1:0] label;
	} side_a_t;

	// side data once the normalized coordinates are known
	typedef struct packed {
		logic             xneg;
		logic             yneg;
		logic [XN_W-1:0]  xn;
		logic [XN_W-1:0]  yn;
		logic [D_W-1:0]   depth;
		logic [LAB_W-1:0] label;
	} side_b_t;

endpackage

// ===== rtl/dpb_ifs.sv =====
// valid/ready channel interfaces for depth pixels and camera-frame points
interface dpb_pixel_if #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic [COORD_BITS-1:0]       pixel_row;
	logic [COORD_BITS-1:0]       pixel_col;
	logic [dpb_pkg::D_W-1:0]     depth_mm;
	logic [dpb_pkg::LAB_W-1:0]   label;

	modport source (output valid, pixel_row, pixel_col, depth_mm, label, input ready);
	modport sink (input valid, pixel_row, pixel_col, depth_mm, label, output ready);
endinterface

interface dpb_point_if;
	logic                             valid;
	logic                             ready;
	logic signed [dpb_pkg::XY_W-1:0]  point_x;
	logic signed [dpb_pkg::XY_W-1:0]  point_y;
	logic [dpb_pkg::Z_W-1:0]          point_z;
	logic [dpb_pkg::LAB_W-1:0]        point_label;

	modport source (output valid, point_x, point_y, point_z, point_label, input ready);
	modport sink (input valid, point_x, point_y, point_z, point_label, output ready);
endinterface

// ===== rtl/dpb_div_cell.sv =====
// one restoring division step: one quotient bit per cell
module dpb_div_cell #(
	parameter int DIV_W = 20,
	parameter int NUM_W = 32,
	parameter int QUO_W = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DIV_W-1:0] rem_i,
	input  logic [NUM_W-1:0] num_i,
	input  logic [QUO_W-1:0] quo_i,
	input  logic [DIV_W-1:0] dvs_i,
	output logic [DIV_W-1:0] rem_o,
	output logic [NUM_W-1:0] num_o,
	output logic [QUO_W-1:0] quo_o,
	output logic [DIV_W-1:0] dvs_o
);
	logic [DIV_W:0] trial;
	logic [DIV_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_i, num_i[NUM_W-1]};
		ge    = trial >= {1'b0, dvs_i};
		diff  = trial - {1'b0, dvs_i};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_o <= num_i << 1;
			quo_o <= {quo_i[QUO_W-2:0], ge};
			dvs_o <= dvs_i;
		end
	end
endmodule

// ===== rtl/dpb_sqrt_cell.sv =====
// one digit-by-digit square root step: one root bit per cell
module dpb_sqrt_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [dpb_pkg::REM_W-1:0]    rem_i,
	input  logic [dpb_pkg::ROOT_W-1:0]   root_i,
	input  logic [dpb_pkg::NORM_W-1:0]   op_i,
	output logic [dpb_pkg::REM_W-1:0]    rem_o,
	output logic [dpb_pkg::ROOT_W-1:0]   root_o,
	output logic [dpb_pkg::NORM_W-1:0]   op_o
);
	logic [dpb_pkg::REM_W+1:0] cur;
	logic [dpb_pkg::REM_W+1:0] trial;
	logic [dpb_pkg::REM_W+1:0] diff;
	logic                      ge;

	always_comb begin
		cur   = {rem_i, op_i[dpb_pkg::NORM_W-1 -: 2]};
		trial = {2'b00, root_i, 2'b01};
		ge    = cur >= trial;
		diff  = cur - trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[dpb_pkg::REM_W-1:0] : cur[dpb_pkg::REM_W-1:0];
			root_o <= {root_i[dpb_pkg::ROOT_W-2:0], ge};
			op_o   <= op_i << 2;
		end
	end
endmodule

// ===== rtl/depth_pixel_backprojection_unit.sv =====
// depth pixel back-projection unit: pinhole depth pixel to camera-frame point
// Takes one depth pixel per clock and gives one camera-frame point (Q.8 mm) per kept pixel.
// Pixels with zero depth or depth outside [min_range_mm, max_range_mm] are dropped at the
// entry and leave a bubble. The datapath is a chain of one-bit cells: 32 restoring divide
// cells for the normalized x/y coordinates, 32 square root cells for the ray norm and
// 16+FRAC_BITS divide cells for z, plus entry, square, sum, multiply and output stages.
// Throughput is one pixel per clock; the whole chain advances together and stops only
// while a finished point is not taken. The user must write the configuration registers
// through cfg_wr_en/cfg_index/cfg_data only while idle; the unit does not enforce it.
module depth_pixel_backprojection_unit #(
	parameter int COORD_BITS = dpb_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dpb_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dpb_pkg::IDX_W-1:0]   cfg_index,
	input  logic [dpb_pkg::FOC_W-1:0]   cfg_data,
	dpb_pixel_if.sink                   pixel,
	dpb_point_if.source                 point
);
	localparam int FOC_W = dpb_pkg::FOC_W;
	localparam int MAG_W = (COORD_BITS + FRAC_BITS > FOC_W) ? COORD_BITS + FRAC_BITS : FOC_W;
	localparam int XS    = dpb_pkg::XDIV_STEPS;
	localparam int RS    = dpb_pkg::ROOT_STEPS;
	localparam int ZN    = 16 + FRAC_BITS;

	// configuration registers
	logic [FOC_W-1:0]        focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [dpb_pkg::D_W-1:0] min_range_q, max_range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q   <= dpb_pkg::FOCAL_X_RST;
			focal_y_q   <= dpb_pkg::FOCAL_Y_RST;
			center_x_q  <= dpb_pkg::CENTER_X_RST;
			center_y_q  <= dpb_pkg::CENTER_Y_RST;
			min_range_q <= dpb_pkg::MIN_RANGE_RST;
			max_range_q <= dpb_pkg::MAX_RANGE_RST;
		end else if (cfg_wr_en) begin
			case (dpb_pkg::cfg_reg_t'(cfg_index))
				dpb_pkg::REG_FOCAL_X:   focal_x_q   <= cfg_data;
				dpb_pkg::REG_FOCAL_Y:   focal_y_q   <= cfg_data;
				dpb_pkg::REG_CENTER_X:  center_x_q  <= cfg_data;
				dpb_pkg::REG_CENTER_Y:  center_y_q  <= cfg_data;
				dpb_pkg::REG_MIN_RANGE: min_range_q <= cfg_data[dpb_pkg::D_W-1:0];
				dpb_pkg::REG_MAX_RANGE: max_range_q <= cfg_data[dpb_pkg::D_W-1:0];
				default: ;
			endcase
		end
	end

	// the whole chain moves when the output register is empty or being drained
	logic vo_q;
	logic adv;
	assign adv = !vo_q || point.ready;
	assign pixel.ready = adv;

	// entry: range check, offset from principal point, overflow check of the divide
	logic [FOC_W-1:0] fx_eff, fy_eff;
	logic [MAG_W:0]   px_ext, py_ext, cx_ext, cy_ext;
	logic             xneg, yneg, keep;
	logic [MAG_W-1:0] xmag, ymag, xhi, yhi;

	always_comb begin
		fx_eff = (focal_x_q == '0) ? FOC_W'(1) : focal_x_q;
		fy_eff = (focal_y_q == '0) ? FOC_W'(1) : focal_y_q;
		px_ext = (MAG_W + 1)'(pixel.pixel_col) << FRAC_BITS;
		py_ext = (MAG_W + 1)'(pixel.pixel_row) << FRAC_BITS;
		cx_ext = (MAG_W + 1)'(center_x_q);
		cy_ext = (MAG_W + 1)'(center_y_q);
		xneg   = px_ext < cx_ext;
		yneg   = py_ext < cy_ext;
		xmag   = MAG_W'(xneg ? cx_ext - px_ext : px_ext - cx_ext);
		ymag   = MAG_W'(yneg ? cy_ext - py_ext : py_ext - cy_ext);
		xhi    = xmag >> 16;
		yhi    = ymag >> 16;
		keep   = (pixel.depth_mm != '0) && (pixel.depth_mm >= min_range_q)
			&& (pixel.depth_mm <= max_range_q);
	end

	logic                    ve_s1;
	dpb_pkg::side_a_t        sae_s1;
	logic [FOC_W-1:0]        xr_s1, yr_s1, xd_s1, yd_s1;
	logic [dpb_pkg::XQ_W-1:0] xnum_s1, ynum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ve_s1 <= 1'b0;
		end else if (adv) begin
			ve_s1 <= pixel.valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sae_s1.xneg  <= xneg;
			sae_s1.yneg  <= yneg;
			sae_s1.xovf  <= xhi >= MAG_W'(fx_eff);
			sae_s1.yovf  <= yhi >= MAG_W'(fy_eff);
			sae_s1.depth <= pixel.depth_mm;
			sae_s1.label <= pixel.label;
			xr_s1   <= FOC_W'(xhi);
			yr_s1   <= FOC_W'(yhi);
			xnum_s1 <= {xmag[15:0], 16'h0000};
			ynum_s1 <= {ymag[15:0], 16'h0000};
			xd_s1   <= fx_eff;
			yd_s1   <= fy_eff;
		end
	end

	// normalized coordinate division chain, x and y side by side
	wire [FOC_W-1:0]         xr_w [0:XS];
	wire [FOC_W-1:0]         yr_w [0:XS];
	wire [FOC_W-1:0]         xd_w [0:XS];
	wire [FOC_W-1:0]         yd_w [0:XS];
	wire [dpb_pkg::XQ_W-1:0] xnum_w [0:XS];
	wire [dpb_pkg::XQ_W-1:0] ynum_w [0:XS];
	wire [dpb_pkg::XQ_W-1:0] xq_w [0:XS];
	wire [dpb_pkg::XQ_W-1:0] yq_w [0:XS];
	dpb_pkg::side_a_t        sa_q [1:XS];
	logic                    va_q [1:XS];

	assign xr_w[0]   = xr_s1;
	assign yr_w[0]   = yr_s1;
	assign xd_w[0]   = xd_s1;
	assign yd_w[0]   = yd_s1;
	assign xnum_w[0] = xnum_s1;
	assign ynum_w[0] = ynum_s1;
	assign xq_w[0]   = '0;
	assign yq_w[0]   = '0;

	for (genvar k = 0; k < XS; k++) begin : g_xdiv
		dpb_div_cell #(.DIV_W(FOC_W), .NUM_W(dpb_pkg::XQ_W), .QUO_W(dpb_pkg::XQ_W)) u_xcell (
			.clk(clk), .en(adv),
			.rem_i(xr_w[k]), .num_i(xnum_w[k]), .quo_i(xq_w[k]), .dvs_i(xd_w[k]),
			.rem_o(xr_w[k+1]), .num_o(xnum_w[k+1]), .quo_o(xq_w[k+1]), .dvs_o(xd_w[k+1])
		);
		dpb_div_cell #(.DIV_W(FOC_W), .NUM_W(dpb_pkg::XQ_W), .QUO_W(dpb_pkg::XQ_W)) u_ycell (
			.clk(clk), .en(adv),
			.rem_i(yr_w[k]), .num_i(ynum_w[k]), .quo_i(yq_w[k]), .dvs_i(yd_w[k]),
			.rem_o(yr_w[k+1]), .num_o(ynum_w[k+1]), .quo_o(yq_w[k+1]), .dvs_o(yd_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					va_q[1] <= 1'b0;
				end else if (adv) begin
					va_q[1] <= ve_s1;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sa_q[1] <= sae_s1;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					va_q[k+1] <= 1'b0;
				end else if (adv) begin
					va_q[k+1] <= va_q[k];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sa_q[k+1] <= sa_q[k];
				end
			end
		end
	end

	// saturate the normalized coordinates and square them
	logic [dpb_pkg::XN_W-1:0] xn_c, yn_c;
	assign xn_c = (sa_q[XS].xovf || xq_w[XS][dpb_pkg::XQ_W-1]) ? dpb_pkg::XN_SAT
		: xq_w[XS][dpb_pkg::XN_W-1:0];
	assign yn_c = (sa_q[XS].yovf || yq_w[XS][dpb_pkg::XQ_W-1]) ? dpb_pkg::XN_SAT
		: yq_w[XS][dpb_pkg::XN_W-1:0];

	logic                     vm_s2;
	dpb_pkg::side_b_t         sb_s2;
	logic [dpb_pkg::SQ_W-1:0] sqx_s2, sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vm_s2 <= 1'b0;
		end else if (adv) begin
			vm_s2 <= va_q[XS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s2.xneg  <= sa_q[XS].xneg;
			sb_s2.yneg  <= sa_q[XS].yneg;
			sb_s2.xn    <= xn_c;
			sb_s2.yn    <= yn_c;
			sb_s2.depth <= sa_q[XS].depth;
			sb_s2.label <= sa_q[XS].label;
			sqx_s2 <= dpb_pkg::SQ_W'(xn_c * xn_c);
			sqy_s2 <= dpb_pkg::SQ_W'(yn_c * yn_c);
		end
	end

	// ray norm squared in Q.32
	logic                       vn_s3;
	dpb_pkg::side_b_t           sb_s3;
	logic [dpb_pkg::NORM_W-1:0] norm_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vn_s3 <= 1'b0;
		end else if (adv) begin
			vn_s3 <= vm_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb_s3   <= sb_s2;
			norm_s3 <= dpb_pkg::NORM_ONE + dpb_pkg::NORM_W'(sqx_s2)
				+ dpb_pkg::NORM_W'(sqy_s2);
		end
	end

	// square root chain
	wire [dpb_pkg::REM_W-1:0]  srem_w [0:RS];
	wire [dpb_pkg::ROOT_W-1:0] root_w [0:RS];
	wire [dpb_pkg::NORM_W-1:0] sop_w [0:RS];
	dpb_pkg::side_b_t          sbr_q [1:RS];
	logic                      vr_q [1:RS];

	assign srem_w[0] = '0;
	assign root_w[0] = '0;
	assign sop_w[0]  = norm_s3;

	for (genvar k = 0; k < RS; k++) begin : g_sqrt
		dpb_sqrt_cell u_cell (
			.clk(clk), .en(adv),
			.rem_i(srem_w[k]), .root_i(root_w[k]), .op_i(sop_w[k]),
			.rem_o(srem_w[k+1]), .root_o(root_w[k+1]), .op_o(sop_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vr_q[1] <= 1'b0;
				end else if (adv) begin
					vr_q[1] <= vn_s3;
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sbr_q[1] <= sb_s3;
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vr_q[k+1] <= 1'b0;
				end else if (adv) begin
					vr_q[k+1] <= vr_q[k];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sbr_q[k+1] <= sbr_q[k];
				end
			end
		end
	end

	// z division chain: depth is always below the root, so it is the first remainder
	wire [dpb_pkg::ROOT_W-1:0] zr_w [0:ZN];
	wire [dpb_pkg::ROOT_W-1:0] zd_w [0:ZN];
	wire                       znum_w [0:ZN];
	wire [ZN-1:0]              zq_w [0:ZN];
	dpb_pkg::side_b_t          sbz_q [1:ZN];
	logic                      vz_q [1:ZN];

	assign zr_w[0]   = dpb_pkg::ROOT_W'(sbr_q[RS].depth);
	assign zd_w[0]   = root_w[RS];
	assign znum_w[0] = 1'b0;
	assign zq_w[0]   = '0;

	for (genvar k = 0; k < ZN; k++) begin : g_zdiv
		dpb_div_cell #(.DIV_W(dpb_pkg::ROOT_W), .NUM_W(1), .QUO_W(ZN)) u_cell (
			.clk(clk), .en(adv),
			.rem_i(zr_w[k]), .num_i(znum_w[k]), .quo_i(zq_w[k]), .dvs_i(zd_w[k]),
			.rem_o(zr_w[k+1]), .num_o(znum_w[k+1]), .quo_o(zq_w[k+1]), .dvs_o(zd_w[k+1])
		);
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vz_q[1] <= 1'b0;
				end else if (adv) begin
					vz_q[1] <= vr_q[RS];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sbz_q[1] <= sbr_q[RS];
				end
			end
		end else begin : g_rest
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vz_q[k+1] <= 1'b0;
				end else if (adv) begin
					vz_q[k+1] <= vz_q[k];
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					sbz_q[k+1] <= sbz_q[k];
				end
			end
		end
	end

	// clamp z, then scale the normalized coordinates by it
	logic [dpb_pkg::Z_W-1:0] z_c;
	assign z_c = (zq_w[ZN] > ZN'(dpb_pkg::Z_MAX)) ? dpb_pkg::Z_MAX
		: dpb_pkg::Z_W'(zq_w[ZN]);

	logic                       vp_s4;
	logic                       xneg_s4, yneg_s4;
	logic [dpb_pkg::LAB_W-1:0]  lab_s4;
	logic [dpb_pkg::Z_W-1:0]    z_s4;
	logic [dpb_pkg::PROD_W-1:0] px_s4, py_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vp_s4 <= 1'b0;
		end else if (adv) begin
			vp_s4 <= vz_q[ZN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xneg_s4 <= sbz_q[ZN].xneg;
			yneg_s4 <= sbz_q[ZN].yneg;
			lab_s4  <= sbz_q[ZN].label;
			z_s4    <= z_c;
			px_s4   <= dpb_pkg::PROD_W'(sbz_q[ZN].xn * z_c);
			py_s4   <= dpb_pkg::PROD_W'(sbz_q[ZN].yn * z_c);
		end
	end

	// drop the Q.16 scale, apply sign and clamp into the output fields
	logic [dpb_pkg::PROD_W-17:0] xm, ym;
	logic [dpb_pkg::XY_W-1:0]    xf, yf;

	always_comb begin
		xm = px_s4[dpb_pkg::PROD_W-1:16];
		ym = py_s4[dpb_pkg::PROD_W-1:16];
		if (xneg_s4) begin
			xf = (xm > (dpb_pkg::PROD_W - 16)'(dpb_pkg::XY_MIN)) ? dpb_pkg::XY_MIN
				: dpb_pkg::XY_W'(-xm);
		end else begin
			xf = (xm > (dpb_pkg::PROD_W - 16)'(dpb_pkg::XY_MAX)) ? dpb_pkg::XY_MAX
				: dpb_pkg::XY_W'(xm);
		end
		if (yneg_s4) begin
			yf = (ym > (dpb_pkg::PROD_W - 16)'(dpb_pkg::XY_MIN)) ? dpb_pkg::XY_MIN
				: dpb_pkg::XY_W'(-ym);
		end else begin
			yf = (ym > (dpb_pkg::PROD_W - 16)'(dpb_pkg::XY_MAX)) ? dpb_pkg::XY_MAX
				: dpb_pkg::XY_W'(ym);
		end
	end

	// output register
	logic [dpb_pkg::XY_W-1:0]  x_q, y_q;
	logic [dpb_pkg::Z_W-1:0]   z_q;
	logic [dpb_pkg::LAB_W-1:0] lab_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (adv) begin
			vo_q <= vp_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_q   <= xf;
			y_q   <= yf;
			z_q   <= z_s4;
			lab_q <= lab_s4;
		end
	end

	assign point.valid       = vo_q;
	assign point.point_x     = signed'(x_q);
	assign point.point_y     = signed'(y_q);
	assign point.point_z     = z_q;
	assign point.point_label = lab_q;
endmodule
